// ===== hw/rtl/dof_pkg.sv =====
// dof_pkg: types, codes and defaults shared by the DHCPv4 option finder.
// No dependencies; compile first.
package dof_pkg;

   localparam int MAX_PACKET_BYTES_DEF = 2048;
   localparam int OPTIONS_START_DEF    = 240;

   localparam int DATA_W   = 8;
   localparam int STATUS_W = 2;
   localparam int OFFSET_W = 11;
   localparam int LENGTH_W = 8;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;

   localparam logic [DATA_W-1:0] CODE_PAD     = 8'h00;
   localparam logic [DATA_W-1:0] CODE_END     = 8'hFF;
   localparam logic [DATA_W-1:0] TARGET_RESET = 8'd67;

   localparam logic [CSR_AW-1:0] CSR_TARGET_CODE = 2'd0;

   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_END_SEEN  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 2'd3;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_CODE   = 5'b00010,
      PH_LEN    = 5'b00100,
      PH_VALUE  = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic                have;
      logic [STATUS_W-1:0] scan_status;
      logic [OFFSET_W-1:0] value_offset;
      logic [LENGTH_W-1:0] value_length;
   } dof_result_type;

endpackage

// ===== hw/rtl/dof_if.sv =====
// Stream interfaces for the DHCPv4 option finder: packet bytes in, scan results out.
// Depends on dof_pkg for field widths.
interface dof_req_if;
   import dof_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   data_byte;
   logic                last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface dof_rsp_if;
   import dof_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] scan_status;
   logic [OFFSET_W-1:0] value_offset;
   logic [LENGTH_W-1:0] value_length;

   modport source (output valid, scan_status, value_offset, value_length, input ready);
   modport sink   (input valid, scan_status, value_offset, value_length, output ready);
endinterface

// ===== hw/rtl/dhcpv4_option_finder_unit.sv =====
// dhcpv4_option_finder_unit: top level of the DHCPv4 option finder.
// Depends on dof_pkg, dof_req_if / dof_rsp_if and dof_scan.
//
//   channel | direction | beat contents                           | handshake
//   req_bus | in        | data_byte, last_byte                    | valid/ready
//   rsp_bus | out       | scan_status, value_offset, value_length | valid/ready
//   csr_*   | in        | target_code at byte address 0           | APB write
//
// One byte beat is taken every cycle while no stalled result holds it back; a beat
// waits in the input register, and its result (if any) loads the output register.
// Reset clears the walk state, both register valids and sets target_code to 67.
// A result stalled at rsp_bus holds back only the byte beat that makes a new
// result; bytes that make none keep flowing through the input register.
module dhcpv4_option_finder_unit #(
   parameter int MAX_PACKET_BYTES = dof_pkg::MAX_PACKET_BYTES_DEF,
   parameter int OPTIONS_START    = dof_pkg::OPTIONS_START_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   dof_req_if.sink                     req_bus,
   dof_rsp_if.source                   rsp_bus,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [dof_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [dof_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [dof_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import dof_pkg::*;

   logic [DATA_W-1:0]   target_ff;
   logic                csr_write;

   logic                in_valid_ff;
   logic [DATA_W-1:0]   in_byte_ff;
   logic                in_last_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic [LENGTH_W-1:0] rsp_length_ff;

   dof_result_type      res;
   logic                out_free, step, take_req;

   // Configuration port: always ready, target code at address 0.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == CSR_TARGET_CODE) ? CSR_DW'(target_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
      end else if (csr_write && csr_paddr == CSR_TARGET_CODE) begin
         target_ff <= csr_pwdata[DATA_W-1:0];
      end
   end

   // Advance the held byte when it makes no result or the output slot frees up.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign step     = in_valid_ff && (!res.have || out_free);
   assign req_bus.ready = !in_valid_ff || step;
   assign take_req = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_req) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   dof_scan #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
      .OPTIONS_START    (OPTIONS_START)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_byte_ff),
      .last_byte   (in_last_ff),
      .target_code (target_ff),
      .result      (res)
   );

   // Output register: load a fresh result, drop the beat once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && res.have) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res.have) begin
         rsp_status_ff <= res.scan_status;
         rsp_offset_ff <= res.value_offset;
         rsp_length_ff <= res.value_length;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.scan_status  = rsp_status_ff;
   assign rsp_bus.value_offset = rsp_offset_ff;
   assign rsp_bus.value_length = rsp_length_ff;

`ifndef NO_ASSERTIONS
   // A new result never lands on a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (step && res.have) |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result register overwritten while stalled");

   // Only a found result carries offset and length.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_FOUND) |->
      (rsp_offset_ff == '0 && rsp_length_ff == '0))
      else $error("offset or length set on a result other than found");

   // A byte held back in the input register keeps its contents.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step) |=>
      (in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff)))
      else $error("held input byte changed");

   // An empty input register always takes a beat.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_bus.ready)
      else $error("input stage empty but not ready");
`endif

endmodule

// ===== hw/rtl/dof_scan.sv =====
// dof_scan: per-byte option walk state and its next-state logic.
// Depends on dof_pkg.
module dof_scan #(
   parameter int MAX_PACKET_BYTES = dof_pkg::MAX_PACKET_BYTES_DEF,
   parameter int OPTIONS_START    = dof_pkg::OPTIONS_START_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [dof_pkg::DATA_W-1:0]    data_byte,
   input  logic                          last_byte,
   input  logic [dof_pkg::DATA_W-1:0]    target_code,
   output dof_pkg::dof_result_type       result
);
   import dof_pkg::*;

   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_PACKET_BYTES - 1);

   phase_type             phase_ff, phase_in, work_phase;
   logic [POS_W-1:0]      pos_ff, pos_in, pos_inc;
   logic [LENGTH_W-1:0]   skip_ff, skip_in, skip_dec;
   logic                  match_ff, match_in;
   logic [OFFSET_W-1:0]   hoff_ff, hoff_in, off_next;
   logic [LENGTH_W-1:0]   hlen_ff, hlen_in;
   logic                  eff_last, at_options, new_packet;

   assign pos_inc    = pos_ff + 1'b1;
   assign off_next   = OFFSET_W'(pos_inc);
   assign skip_dec   = skip_ff - 1'b1;
   assign eff_last   = last_byte || (pos_ff >= LAST_POS);
   assign at_options = 32'(pos_ff) >= 32'(OPTIONS_START);
   assign work_phase = (phase_ff == PH_HEADER && at_options) ? PH_CODE : phase_ff;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      skip_in    = skip_ff;
      match_in   = match_ff;
      hoff_in    = hoff_ff;
      hlen_in    = hlen_ff;
      new_packet = 1'b0;
      result     = '0;

      if (phase_ff == PH_DONE) begin
         new_packet = last_byte;
      end else begin
         phase_in = work_phase;
         unique case (work_phase)
            PH_CODE: begin
               if (data_byte == CODE_END) begin
                  result.have        = 1'b1;
                  result.scan_status = ST_END_SEEN;
               end else if (data_byte != CODE_PAD) begin
                  match_in = (data_byte == target_code);
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (match_ff) begin
                  hoff_in = off_next;
                  hlen_in = data_byte;
               end
               if (data_byte == '0) begin
                  if (match_ff) begin
                     result.have         = 1'b1;
                     result.scan_status  = ST_FOUND;
                     result.value_offset = off_next;
                  end else begin
                     phase_in = PH_CODE;
                  end
               end else begin
                  skip_in  = data_byte;
                  phase_in = PH_VALUE;
               end
            end
            PH_VALUE: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  if (match_ff) begin
                     result.have         = 1'b1;
                     result.scan_status  = ST_FOUND;
                     result.value_offset = hoff_ff;
                     result.value_length = hlen_ff;
                  end else begin
                     phase_in = PH_CODE;
                  end
               end
            end
            PH_HEADER, PH_DONE: begin
            end
            default: begin
            end
         endcase

         if (!result.have && eff_last) begin
            result.have         = 1'b1;
            result.scan_status  = (phase_in == PH_LEN || phase_in == PH_VALUE) ?
                                  ST_TRUNCATED : ST_NO_MATCH;
            result.value_offset = '0;
            result.value_length = '0;
         end

         if (result.have) begin
            if (last_byte) begin
               new_packet = 1'b1;
            end else begin
               phase_in = PH_DONE;
               pos_in   = pos_inc;
            end
         end else begin
            pos_in = pos_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         skip_ff  <= '0;
         match_ff <= 1'b0;
         hoff_ff  <= '0;
         hlen_ff  <= '0;
      end else if (step) begin
         if (new_packet) begin
            phase_ff <= PH_HEADER;
            pos_ff   <= '0;
            skip_ff  <= '0;
            match_ff <= 1'b0;
            hoff_ff  <= '0;
            hlen_ff  <= '0;
         end else begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            skip_ff  <= skip_in;
            match_ff <= match_in;
            hoff_ff  <= hoff_in;
            hlen_ff  <= hlen_in;
         end
      end
   end

endmodule
